// ===== sv/spq_pkg.sv =====
// spq_pkg: shared widths, action and status codes, sequencer states for the
// sorted priority queue. No dependencies.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int ACTION_W  = 3;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int STATUS_W  = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_OFFER      = 3'd0,
        ACT_PEEK       = 3'd1,
        ACT_POLL       = 3'd2,
        ACT_READ_AT    = 3'd3,
        ACT_REMOVE_VAL = 3'd4,
        ACT_REMOVE_AT  = 3'd5
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PLACE,
        ST_RESP
    } state_t;

endpackage

// ===== sv/spq_if.sv =====
// spq_req_if / spq_rsp_if: valid/ready channels for queue requests and results.
// Depends on spq_pkg.
`timescale 1ns / 1ps

interface spq_req_if #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 16
);
    import spq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [ACTION_W-1:0]    action;
    logic [KEY_WIDTH-1:0]   item_key;
    logic [VALUE_WIDTH-1:0] item_value;
    logic [POS_W-1:0]       position;

    modport source (output valid, action, item_key, item_value, position, input ready);
    modport sink   (input valid, action, item_key, item_value, position, output ready);
endinterface

interface spq_rsp_if #(
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 16
);
    import spq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [KEY_WIDTH-1:0]   out_key;
    logic [VALUE_WIDTH-1:0] out_value;
    logic [POS_W-1:0]       insert_position;
    logic [CNT_OUT_W-1:0]   removed_count;
    logic [CNT_OUT_W-1:0]   queue_size;
    logic [STATUS_W-1:0]    status;

    modport source (output valid, out_key, out_value, insert_position, removed_count,
                    queue_size, status, input ready);
    modport sink   (input valid, out_key, out_value, insert_position, removed_count,
                    queue_size, status, output ready);
endinterface

// ===== sv/sorted_priority_queue_core.sv =====
// Sorted priority queue core: entry memory walked by one compare/move step. Uses spq_pkg, spq_if.
// Offer and remove-by-value walk all entries; poll and remove-at walk from head or position to
// tail; peek/read-at read one entry; full offers and empty or out-of-range requests go straight
// to the result. Each entry is read in ST_READ and may be written in ST_EVAL. One transaction
// at a time: next accept in the cycle after the result loads, later while the previous result
// waits. Reset (rst_n async low) clears count, order and control, not memory.
`timescale 1ns / 1ps

module sorted_priority_queue_core #(
    parameter int CAPACITY    = 16,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);
    import spq_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    state_t                 state_reg, state_next;
    action_t                act_reg, act_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic [IDX_W-1:0]       ins_reg, ins_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       kept_reg, kept_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic                   shift_reg, shift_next;
    logic [KEY_WIDTH-1:0]   res_key_reg, res_key_next;
    logic [VALUE_WIDTH-1:0] res_val_reg, res_val_next;
    status_t                res_status_reg, res_status_next;
    logic                   order_reg;

    logic                   rsp_valid_reg;
    logic [KEY_WIDTH-1:0]   out_key_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [POS_W-1:0]       out_ins_reg;
    logic [CNT_OUT_W-1:0]   out_rem_reg;
    logic [CNT_OUT_W-1:0]   out_size_reg;
    status_t                out_status_reg;
    logic                   out_load;

    logic [KEY_WIDTH-1:0]   key_mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
    logic [KEY_WIDTH-1:0]   rd_key_reg;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [KEY_WIDTH-1:0]   wr_key;
    logic [VALUE_WIDTH-1:0] wr_val;

    logic                   goes_before;
    logic                   last_entry;
    logic                   pos_out_of_range;

    assign goes_before      = order_reg ? (key_reg > rd_key_reg) : (key_reg < rd_key_reg);
    assign last_entry       = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign pos_out_of_range = CMP_W'(req.position) >= CMP_W'(count_reg);

    // entry memory: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[idx_reg];
        rd_val_reg <= val_mem[idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            order_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_wr_en)
            begin
                order_reg <= cfg_wr_data;
            end
            if (out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        key_reg        <= key_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        ins_reg        <= ins_next;
        kept_reg       <= kept_next;
        rem_reg        <= rem_next;
        shift_reg      <= shift_next;
        res_key_reg    <= res_key_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_key_reg    <= res_key_reg;
            out_value_reg  <= res_val_reg;
            out_ins_reg    <= POS_W'(ins_reg);
            out_rem_reg    <= CNT_OUT_W'(rem_reg);
            out_size_reg   <= CNT_OUT_W'(count_reg);
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        idx_next        = idx_reg;
        ins_next        = ins_reg;
        count_next      = count_reg;
        kept_next       = kept_reg;
        rem_next        = rem_reg;
        shift_next      = shift_reg;
        res_key_next    = res_key_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_key          = rd_key_reg;
        wr_val          = rd_val_reg;
        out_load        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    act_next        = action_t'(req.action);
                    key_next        = req.item_key;
                    val_next        = req.item_value;
                    idx_next        = '0;
                    ins_next        = '0;
                    kept_next       = '0;
                    rem_next        = '0;
                    shift_next      = 1'b0;
                    res_key_next    = '0;
                    res_val_next    = '0;
                    res_status_next = STAT_OK;
                    state_next      = ST_RESP;
                    case (action_t'(req.action)) inside
                        ACT_OFFER:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                res_status_next = STAT_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = ST_PLACE;
                            end
                            else
                            begin
                                ins_next   = IDX_W'(count_reg);
                                state_next = ST_READ;
                            end
                        end
                        ACT_PEEK, ACT_POLL:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                state_next = ST_READ;
                            end
                        end
                        ACT_READ_AT, ACT_REMOVE_AT:
                        begin
                            if (pos_out_of_range)
                            begin
                                res_status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                idx_next   = IDX_W'(req.position);
                                state_next = ST_READ;
                            end
                        end
                        ACT_REMOVE_VAL:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                case (act_reg)
                    ACT_OFFER:
                    begin
                        // walk from the head; once placed, carry each displaced entry down a slot
                        if (shift_reg || goes_before)
                        begin
                            wr_en      = 1'b1;
                            wr_key     = key_reg;
                            wr_val     = val_reg;
                            key_next   = rd_key_reg;
                            val_next   = rd_val_reg;
                            shift_next = 1'b1;
                            if (!shift_reg)
                            begin
                                ins_next = idx_reg;
                            end
                        end
                        if (last_entry)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_READ;
                        end
                    end
                    ACT_REMOVE_VAL:
                    begin
                        // compact survivors toward the head
                        if (rd_val_reg == val_reg)
                        begin
                            rem_next = rem_reg + CNT_W'(1);
                        end
                        else
                        begin
                            wr_en     = 1'b1;
                            wr_addr   = IDX_W'(kept_reg);
                            kept_next = kept_reg + CNT_W'(1);
                        end
                        if (last_entry)
                        begin
                            count_next = (rd_val_reg == val_reg) ? kept_reg
                                                                 : kept_reg + CNT_W'(1);
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            idx_next   = idx_reg + IDX_W'(1);
                            state_next = ST_READ;
                        end
                    end
                    default:
                    begin
                        if (shift_reg)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = idx_reg - IDX_W'(1);
                        end
                        else
                        begin
                            res_key_next = rd_key_reg;
                            res_val_next = rd_val_reg;
                        end
                        if (act_reg == ACT_POLL || act_reg == ACT_REMOVE_AT)
                        begin
                            if (last_entry)
                            begin
                                count_next = count_reg - CNT_W'(1);
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                shift_next = 1'b1;
                                idx_next   = idx_reg + IDX_W'(1);
                                state_next = ST_READ;
                            end
                        end
                        else
                        begin
                            state_next = ST_RESP;
                        end
                    end
                endcase
            end
            ST_PLACE:
            begin
                // new entry or last carried entry goes to the old tail slot
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(count_reg);
                wr_key     = key_reg;
                wr_val     = val_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req.ready           = (state_reg == ST_IDLE);
    assign rsp.valid           = rsp_valid_reg;
    assign rsp.out_key         = out_key_reg;
    assign rsp.out_value       = out_value_reg;
    assign rsp.insert_position = out_ins_reg;
    assign rsp.removed_count   = out_rem_reg;
    assign rsp.queue_size      = out_size_reg;
    assign rsp.status          = out_status_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> $past(state_reg) == ST_READ)
        else $error("evaluate step without memory read");

    a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && $past(state_reg) == ST_RESP) |-> rsp.valid)
        else $error("transaction finished without result");

    a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(state_reg) == ST_EVAL || $past(state_reg) == ST_PLACE))
        else $error("entry count changed outside update step");
`endif

endmodule

// ===== tb/sv/sorted_priority_queue_core_tb.sv =====
// Testbench for sorted_priority_queue_core: directed and random request
// traffic checked against an in-bench model of the sorted queue.
// Depends on spq_pkg, spq_if and sorted_priority_queue_core.
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 16;
    localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [ACTION_W-1:0] ACT_RESERVED_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RESERVED_B = 3'd7;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [VAL_W-1:0]     value;
        logic [POS_W-1:0]     ins_pos;
        logic [CNT_OUT_W-1:0] removed;
        logic [CNT_OUT_W-1:0] size;
        status_t              status;
    } queue_result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;

    spq_req_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W)) req_ch ();
    spq_rsp_if #(.KEY_WIDTH(KEY_W), .VALUE_WIDTH(VAL_W)) rsp_ch ();

    sorted_priority_queue_core #(
        .CAPACITY    (QUEUE_DEPTH),
        .KEY_WIDTH   (KEY_W),
        .VALUE_WIDTH (VAL_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    logic [KEY_W-1:0] held_keys [QUEUE_DEPTH];
    logic [VAL_W-1:0] held_values [QUEUE_DEPTH];
    int               held_count;
    bit               order_desc;

    queue_result_t pending_results [$];
    int            error_count;
    int            cycle_count;
    int            send_idle_pct;
    int            recv_stall_pct;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit goes_ahead(logic [KEY_W-1:0] new_key, logic [KEY_W-1:0] old_key);
        return order_desc ? (new_key > old_key) : (new_key < old_key);
    endfunction

    function automatic void drop_entry(int idx);
        for (int i = idx; i + 1 < held_count; i++)
        begin
            held_keys[i]   = held_keys[i + 1];
            held_values[i] = held_values[i + 1];
        end
        held_count--;
    endfunction

    function automatic queue_result_t apply_request(logic [ACTION_W-1:0] act,
                                                    logic [KEY_W-1:0] key,
                                                    logic [VAL_W-1:0] val,
                                                    logic [POS_W-1:0] pos);
        queue_result_t res;
        int            at;
        int            kept;
        bit            found;
        res = '0;
        res.status = STAT_OK;
        case (act)
            ACT_OFFER:
            begin
                if (held_count >= QUEUE_DEPTH)
                    res.status = STAT_FULL;
                else
                begin
                    at = held_count;
                    found = 1'b0;
                    for (int i = 0; i < held_count; i++)
                    begin
                        if (!found && goes_ahead(key, held_keys[i]))
                        begin
                            at = i;
                            found = 1'b1;
                        end
                    end
                    for (int i = held_count; i > at; i--)
                    begin
                        held_keys[i]   = held_keys[i - 1];
                        held_values[i] = held_values[i - 1];
                    end
                    held_keys[at]   = key;
                    held_values[at] = val;
                    held_count++;
                    res.ins_pos = at[POS_W-1:0];
                end
            end
            ACT_PEEK, ACT_POLL:
            begin
                if (held_count == 0)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.key   = held_keys[0];
                    res.value = held_values[0];
                    if (act == ACT_POLL)
                        drop_entry(0);
                end
            end
            ACT_READ_AT, ACT_REMOVE_AT:
            begin
                if (int'(pos) >= held_count)
                    res.status = STAT_EMPTY;
                else
                begin
                    res.key   = held_keys[pos];
                    res.value = held_values[pos];
                    if (act == ACT_REMOVE_AT)
                        drop_entry(int'(pos));
                end
            end
            ACT_REMOVE_VAL:
            begin
                kept = 0;
                for (int i = 0; i < held_count; i++)
                begin
                    if (held_values[i] == val)
                        res.removed++;
                    else
                    begin
                        held_keys[kept]   = held_keys[i];
                        held_values[kept] = held_values[i];
                        kept++;
                    end
                end
                held_count = kept;
            end
            default:
            begin
            end
        endcase
        res.size = held_count[CNT_OUT_W-1:0];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [KEY_W-1:0] exp_val,
                               input logic [KEY_W-1:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_val, act_val);
            error_count++;
        end
    endtask

    // result checker: each accepted transaction against the oldest prediction
    always @(posedge clk)
    begin
        queue_result_t exp_res;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none actual key %0h",
                         $time, rsp_ch.out_key);
                error_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                check_field("out_key", exp_res.key, rsp_ch.out_key);
                check_field("out_value", KEY_W'(exp_res.value), KEY_W'(rsp_ch.out_value));
                check_field("insert_position", KEY_W'(exp_res.ins_pos),
                            KEY_W'(rsp_ch.insert_position));
                check_field("removed_count", KEY_W'(exp_res.removed),
                            KEY_W'(rsp_ch.removed_count));
                check_field("queue_size", KEY_W'(exp_res.size), KEY_W'(rsp_ch.queue_size));
                check_field("status", KEY_W'(exp_res.status), KEY_W'(rsp_ch.status));
            end
        end
    end

    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        req_ch.valid      = 1'b1;
        req_ch.action     = act;
        req_ch.item_key   = key;
        req_ch.item_value = val;
        req_ch.position   = pos;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pending_results.push_back(apply_request(act, key, val, pos));
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_for_results(input int extra_cycles);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (extra_cycles) @(negedge clk);
    endtask

    task automatic write_order(input bit descending);
        wait_for_results(SETTLE_CYCLES);
        cfg_wr_data = descending;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en  = 1'b0;
        order_desc = descending;
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(15));
            default: return KEY_W'($urandom);
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(7))
            0:          return '1;
            1:          return '0;
            2, 3, 4, 5: return VAL_W'($urandom_range(3));
            default:    return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        if (held_count > 0 && $urandom_range(3) != 0)
            return POS_W'($urandom_range(held_count - 1));
        return POS_W'($urandom_range(15));
    endfunction

    function automatic logic [ACTION_W-1:0] random_action();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return ACT_OFFER;
        else if (r < 43)
            return ACT_PEEK;
        else if (r < 55)
            return ACT_POLL;
        else if (r < 67)
            return ACT_READ_AT;
        else if (r < 77)
            return ACT_REMOVE_VAL;
        else if (r < 97)
            return ACT_REMOVE_AT;
        else if (r < 98)
            return ACT_RESERVED_A;
        return ACT_RESERVED_B;
    endfunction

    task automatic send_random(input logic [ACTION_W-1:0] act);
        logic [VAL_W-1:0] val;
        val = random_value();
        if (act == ACT_REMOVE_VAL && held_count > 0 && $urandom_range(9) < 6)
            val = held_values[$urandom_range(held_count - 1)];
        send_request(act, random_key(), val, random_position());
    endtask

    task automatic test_empty_queue();
        send_request(ACT_PEEK, '0, '0, '0);
        send_request(ACT_POLL, '1, '1, '1);
        send_request(ACT_READ_AT, '0, '0, '0);
        send_request(ACT_REMOVE_AT, '0, '0, '0);
        send_request(ACT_REMOVE_VAL, '0, '0, '0);
        send_request(ACT_RESERVED_A, 32'h1234_5678, 16'hABCD, 4'd3);
        send_request(ACT_RESERVED_B, '1, '1, '1);
    endtask

    task automatic test_ascending_ties();
        send_request(ACT_OFFER, 32'd5, 16'h0011, '0);
        send_request(ACT_OFFER, '0, '1, '0);
        send_request(ACT_OFFER, '1, 16'h0022, '0);
        send_request(ACT_OFFER, 32'd5, 16'h0033, '0);
        send_request(ACT_OFFER, 32'd5, 16'h0011, '0);
        send_request(ACT_READ_AT, '0, '0, 4'd2);
        send_request(ACT_READ_AT, '0, '0, 4'd15);
        send_request(ACT_REMOVE_VAL, '0, 16'h0011, '0);
        send_request(ACT_REMOVE_AT, '0, '0, 4'd1);
        send_request(ACT_REMOVE_AT, '0, '0, 4'd9);
        send_request(ACT_PEEK, '0, '0, '0);
        send_request(ACT_POLL, '0, '0, '0);
    endtask

    task automatic test_descending_ties();
        send_request(ACT_OFFER, 32'd7, 16'h0001, '0);
        send_request(ACT_OFFER, '1, 16'h0002, '0);
        send_request(ACT_OFFER, 32'd7, 16'h0003, '0);
        send_request(ACT_READ_AT, '0, '0, 4'd2);
        send_request(ACT_POLL, '0, '0, '0);
    endtask

    // bursts that fill to full, drain to empty, or mix freely
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int               sent;
        int               extra;
        logic [ACTION_W-1:0] act;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    extra = $urandom_range(3, 1);
                    while (held_count < QUEUE_DEPTH || extra > 0)
                    begin
                        if (held_count >= QUEUE_DEPTH)
                            extra--;
                        send_random(ACT_OFFER);
                        sent++;
                    end
                end
                3, 4:
                begin
                    extra = $urandom_range(2, 1);
                    while (held_count > 0 || extra > 0)
                    begin
                        if (held_count == 0)
                            extra--;
                        case ($urandom_range(3))
                            0:       act = ACT_REMOVE_AT;
                            1:       act = ACT_PEEK;
                            default: act = ACT_POLL;
                        endcase
                        send_random(act);
                        sent++;
                    end
                end
                default:
                begin
                    repeat ($urandom_range(20, 8))
                    begin
                        act = random_action();
                        send_random(act);
                        if (act <= ACT_REMOVE_AT)
                            sent++;
                    end
                end
            endcase
            if ($urandom_range(19) == 0)
                wait_for_results(0);
        end
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.action     = '0;
        req_ch.item_key   = '0;
        req_ch.item_value = '0;
        req_ch.position   = '0;
        rsp_ch.ready      = 1'b0;
        held_count        = 0;
        order_desc        = 1'b0;
        error_count       = 0;
        cycle_count       = 0;
        send_idle_pct     = 24;
        recv_stall_pct    = 85;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            held_keys[i]   = '0;
            held_values[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_empty_queue();
        test_ascending_ties();
        write_order(1'b1);
        test_descending_ties();
        test_random_traffic(600, 24, 85);
        write_order(1'b0);
        test_random_traffic(600, 85, 24);
        write_order(1'b1);
        test_random_traffic(500, 0, 0);

        wait_for_results(SETTLE_CYCLES);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
